[rtl/vdn_pkg.sv]
// ----------------------------------------------------------------------------
// vdn_pkg: shared types and constants for the vector direction normalizer
// Payload structs for both directions and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package vdn_pkg;

  localparam int InFracBits = 16;
  localparam int InW        = 24;
  localparam int ThrW       = 20;
  localparam int UnitW      = 32;
  localparam int MagW       = 24;   // |to - from| stays below 2^24
  localparam int SqW        = 48;
  localparam int SumW       = 50;
  localparam int RemW       = 116;  // remainder and trial term width
  localparam int ProdW      = 84;   // running m * s
  localparam int RootBits   = 32;
  localparam int NumShift   = 62;

  typedef struct packed {
    logic signed [InW-1:0] from_x;
    logic signed [InW-1:0] from_y;
    logic signed [InW-1:0] from_z;
    logic signed [InW-1:0] to_x;
    logic signed [InW-1:0] to_y;
    logic signed [InW-1:0] to_z;
  } vdn_in_t;

  typedef struct packed {
    logic signed [UnitW-1:0] unit_x;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_z;
    logic                    is_zero;
  } vdn_out_t;

endpackage

[rtl/vector3_direction_normalize.sv]
// ----------------------------------------------------------------------------
// vector3_direction_normalize: unit direction between two 3D points
// One transaction enters per cycle (busy is always low) since the 32-step
// inverse root recurrence is fully pipelined, one result bit per stage. The
// receiver cannot stall the strobe. Reset clears the stage valid bits, done_o
// and the threshold register thr_q.
// ----------------------------------------------------------------------------
module vector3_direction_normalize #(
  parameter int IN_FRAC_BITS = vdn_pkg::InFracBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vdn_pkg::vdn_in_t in_i,
  output logic             done_o,
  output vdn_pkg::vdn_out_t out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int ThrShift = 2 * IN_FRAC_BITS - 32;
  localparam int ShL      = (ThrShift > 0) ? ThrShift : 0;
  localparam int ShR      = (ThrShift < 0) ? -ThrShift : 0;
  localparam int LimW     = vdn_pkg::ThrW + 16;
  localparam int NB       = vdn_pkg::RootBits;

  // configuration
  logic [vdn_pkg::ThrW-1:0] thr_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-vdn_pkg::ThrW){1'b0}}, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      thr_q <= pwdata[vdn_pkg::ThrW-1:0];
    end
  end

  // stage A: differences
  logic                       va_q;
  logic [vdn_pkg::MagW-1:0]   mag_a_q [3];
  logic [2:0]                 neg_a_q;
  logic signed [vdn_pkg::InW:0] diff [3];

  always_comb begin
    diff[0] = {in_i.to_x[vdn_pkg::InW-1], in_i.to_x} - {in_i.from_x[vdn_pkg::InW-1], in_i.from_x};
    diff[1] = {in_i.to_y[vdn_pkg::InW-1], in_i.to_y} - {in_i.from_y[vdn_pkg::InW-1], in_i.from_y};
    diff[2] = {in_i.to_z[vdn_pkg::InW-1], in_i.to_z} - {in_i.from_z[vdn_pkg::InW-1], in_i.from_z};
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      neg_a_q[c] <= diff[c][vdn_pkg::InW];
      mag_a_q[c] <= diff[c][vdn_pkg::InW] ? vdn_pkg::MagW'(-diff[c])
                                          : vdn_pkg::MagW'(diff[c]);
    end
  end

  // stage B: squares
  logic                     vb_q;
  logic [vdn_pkg::SqW-1:0]  sq_b_q [3];
  logic [2:0]               neg_b_q;

  always_ff @(posedge clk_i) begin
    neg_b_q <= neg_a_q;
    for (int c = 0; c < 3; c++) begin
      sq_b_q[c] <= vdn_pkg::SqW'(mag_a_q[c]) * vdn_pkg::SqW'(mag_a_q[c]);
    end
  end

  // root stages: stage k decides bit NB-1-k of m for each component,
  // with m the largest value where m^2 * s <= mag^2 * 2^62
  logic                       vr_q    [NB+1];
  logic [vdn_pkg::RemW-1:0]   rem_q   [NB+1][3];
  logic [vdn_pkg::ProdW-1:0]  prod_q  [NB+1][3];
  logic [NB-1:0]              m_q     [NB+1][3];
  logic [vdn_pkg::SumW-1:0]   s_q     [NB+1];
  logic [2:0]                 neg_q   [NB+1];
  logic                       zero_q  [NB+1];

  // stage C: sum of squares and zero test, loaded as root stage 0
  logic [vdn_pkg::SumW-1:0] sum_b;
  logic [LimW-1:0]          lim;

  assign sum_b = vdn_pkg::SumW'(sq_b_q[0]) + vdn_pkg::SumW'(sq_b_q[1])
               + vdn_pkg::SumW'(sq_b_q[2]);
  assign lim   = (LimW'(thr_q) << ShL) >> ShR;

  always_ff @(posedge clk_i) begin
    s_q[0]    <= sum_b;
    neg_q[0]  <= neg_b_q;
    zero_q[0] <= ({2'b00, sum_b} <= {{(vdn_pkg::SumW + 2 - LimW){1'b0}}, lim});
    for (int c = 0; c < 3; c++) begin
      rem_q[0][c]  <= vdn_pkg::RemW'(sq_b_q[c]) << vdn_pkg::NumShift;
      prod_q[0][c] <= '0;
      m_q[0][c]    <= '0;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_root
    localparam int B = NB - 1 - k;
    logic [vdn_pkg::RemW-1:0] term [3];
    logic [2:0]               take;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        term[c] = ((vdn_pkg::RemW'(prod_q[k][c]) << 1)
                 + (vdn_pkg::RemW'(s_q[k]) << B)) << B;
        take[c] = (term[c] <= rem_q[k][c]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q[k+1] <= 1'b0;
      end else begin
        vr_q[k+1] <= vr_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      s_q[k+1]    <= s_q[k];
      neg_q[k+1]  <= neg_q[k];
      zero_q[k+1] <= zero_q[k];
      for (int c = 0; c < 3; c++) begin
        if (take[c]) begin
          rem_q[k+1][c]  <= rem_q[k][c] - term[c];
          prod_q[k+1][c] <= prod_q[k][c] + (vdn_pkg::ProdW'(s_q[k]) << B);
          m_q[k+1][c]    <= m_q[k][c] | (NB'(1) << B);
        end else begin
          rem_q[k+1][c]  <= rem_q[k][c];
          prod_q[k+1][c] <= prod_q[k][c];
          m_q[k+1][c]    <= m_q[k][c];
        end
      end
    end
  end

  // output: round half away from zero, apply sign
  logic [NB:0]              qr  [3];
  logic [vdn_pkg::UnitW-1:0] qv [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qr[c] = ({1'b0, m_q[NB][c]} + (NB+1)'(1)) >> 1;
      if (zero_q[NB]) begin
        qv[c] = '0;
      end else if (neg_q[NB][c]) begin
        qv[c] = vdn_pkg::UnitW'(-qr[c]);
      end else begin
        qv[c] = vdn_pkg::UnitW'(qr[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_o.unit_x  <= qv[0];
    out_o.unit_y  <= qv[1];
    out_o.unit_z  <= qv[2];
    out_o.is_zero <= zero_q[NB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vr_q[0] <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      va_q    <= start;
      vb_q    <= va_q;
      vr_q[0] <= vb_q;
      done_o  <= vr_q[NB];
    end
  end

endmodule
